// ----- src/lin_frame_deframer_assert.svh -----
// assertion macros for the lin frame deframer rtl
// depends on a clock named clk and an active-low reset named arst_n in the including module
`ifndef LIN_FRAME_DEFRAMER_ASSERT_SVH
`define LIN_FRAME_DEFRAMER_ASSERT_SVH

`ifndef SYNTH

// plain property checked on every rising clock edge outside reset
`define LFD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define LFD_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define LFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`else

`define LFD_ASSERT(lbl, prop, msg)
`define LFD_ASSERT_IMPLY(lbl, ante, cons, msg)
`define LFD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- src/lfd_pkg.sv -----
// shared types, constants and the length decode for the lin frame deframer
// no dependencies
`default_nettype none

package lfd_pkg;

	localparam int unsigned MAX_DATA = 8;

	localparam logic [7:0] SYNC_RESET = 8'h55;
	localparam logic [7:0] ID_MASK    = 8'h3F;

	localparam logic [1:0] SEL_LONG = 2'd3;
	localparam logic [1:0] SEL_MID  = 2'd2;

	localparam logic [3:0] LEN_LONG  = 4'd8;
	localparam logic [3:0] LEN_MID   = 4'd4;
	localparam logic [3:0] LEN_SHORT = 4'd2;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_ID      = 2'd1,
		PH_DATA    = 2'd2,
		PH_DISCARD = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0]                 id;
		logic [3:0]                 count;
		logic [MAX_DATA-1:0][7:0]   data;
		logic [7:0]                 check;
	} frame_t;

	// data length from identifier bits 5:4
	function automatic logic [3:0] length_of_id(input logic [7:0] id);
		logic [7:0] masked;
		logic [3:0] len;
		masked = id & ID_MASK;
		case (masked[5:4])
			SEL_LONG: len = LEN_LONG;
			SEL_MID:  len = LEN_MID;
			default:  len = LEN_SHORT;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

// ----- src/lfd_parse.sv -----
// frame parser: phase machine, identifier, byte index and data store
// depends on lfd_pkg and lin_frame_deframer_assert.svh
`default_nettype none

`include "lin_frame_deframer_assert.svh"

module lfd_parse import lfd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] rx_byte,
	input  wire logic [7:0] sync_value,
	output      logic       emit,
	output      frame_t     frame
);

	phase_t     phase_q, phase_d;
	logic [7:0] held_id_q;
	logic [3:0] expected_len_q;
	logic [3:0] byte_index_q;
	logic [MAX_DATA-1:0][7:0] store_q;
	logic       collect;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		collect = 1'b0;
		emit    = 1'b0;
		if (step) begin
			case (phase_q)
				PH_IDLE: begin
					if (rx_byte != 8'd0)
						phase_d = (rx_byte == sync_value) ? PH_ID : PH_DISCARD;
				end
				PH_ID: begin
					phase_d = PH_DATA;
				end
				PH_DATA: begin
					if (byte_index_q < expected_len_q) begin
						collect = 1'b1;
					end else begin
						emit    = 1'b1;
						phase_d = PH_IDLE;
					end
				end
				PH_DISCARD: begin
					if (rx_byte == 8'd0)
						phase_d = PH_IDLE;
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_id_q      <= 8'd0;
			expected_len_q <= 4'd0;
			byte_index_q   <= 4'd0;
		end else if (step) begin
			if (phase_q == PH_ID) begin
				held_id_q      <= rx_byte;
				expected_len_q <= length_of_id(rx_byte);
				byte_index_q   <= 4'd0;
			end else if (collect) begin
				byte_index_q   <= byte_index_q + 4'd1;
			end else if (emit) begin
				byte_index_q   <= 4'd0;
			end
		end
	end

	// data bytes, written in arrival order
	always_ff @(posedge clk) begin
		if (collect)
			store_q[byte_index_q[2:0]] <= rx_byte;
	end

	always_comb begin
		frame.id    = held_id_q;
		frame.count = expected_len_q;
		frame.check = rx_byte;
		for (int k = 0; k < MAX_DATA; k++) begin
			frame.data[k] = (4'(k) < expected_len_q) ? store_q[k] : 8'd0;
		end
	end

	`LFD_ASSERT_IMPLY(a_emit_full, emit, phase_q == PH_DATA && byte_index_q == expected_len_q, "frame emitted before all data bytes arrived")
	`LFD_ASSERT_IMPLY(a_len_legal, phase_q == PH_DATA, expected_len_q == LEN_SHORT || expected_len_q == LEN_MID || expected_len_q == LEN_LONG, "illegal data length while collecting")
	`LFD_ASSERT(a_index_bound, byte_index_q <= expected_len_q, "byte index ran past data length")
	`LFD_ASSERT_NEXT(a_id_start, step && phase_q == PH_ID, phase_q == PH_DATA && byte_index_q == 4'd0, "identifier did not start collection")

endmodule

`default_nettype wire

// ----- src/lin_frame_deframer.sv -----
// lin frame deframer top level: channel handshakes, sync register, input and result registers
// depends on lfd_pkg and lfd_parse
//
// Takes received LIN bytes on rx_byte, one beat per byte, and delivers one beat per complete
// frame carrying the identifier, the data length (2, 4 or 8), eight data byte fields (those
// at or above the length read zero) and the checksum byte, which is passed through unchecked.
// Zero bytes between frames are skipped; a byte equal to the sync register opens a frame and
// the following byte is always taken as the identifier; any other nonzero byte between frames
// drops traffic up to and including the next zero byte. A byte is registered on acceptance and
// parsed into the result register once it is free, so the block sustains one byte per clock
// while no stall holds it, and a frame is loaded there when its checksum byte is parsed. The only
// throttle is the result register: while it holds an undelivered frame under stall, the byte
// in the input register waits and in_stall rises. The sync register (reset 0x55) is written
// through the cfg channel, which is always ready; write it only while no frame is in flight.
`default_nettype none

module lin_frame_deframer import lfd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,

	// configuration write channel
	input  wire logic       cfg_valid,
	output      logic       cfg_ready,
	input  wire logic [7:0] cfg_data,

	// byte input channel
	input  wire logic       in_valid,
	output      logic       in_stall,
	input  wire logic [7:0] rx_byte,

	// frame result channel
	output      logic       out_valid,
	input  wire logic       out_stall,
	output      logic [7:0] frame_id,
	output      logic [3:0] data_count,
	output      logic [7:0] data_0,
	output      logic [7:0] data_1,
	output      logic [7:0] data_2,
	output      logic [7:0] data_3,
	output      logic [7:0] data_4,
	output      logic [7:0] data_5,
	output      logic [7:0] data_6,
	output      logic [7:0] data_7,
	output      logic [7:0] check_byte
);

	logic [7:0] sync_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	frame_t     frame_q;

	logic       res_free;   // result register can take a frame this cycle
	logic       step;       // byte in the input register is parsed this cycle
	logic       in_accept;
	logic       emit;
	frame_t     frame_d;

	// sync register, written whenever offered
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			sync_q <= cfg_data;
		end
	end

	// handshake control: parse only when a frame produced now has somewhere to go
	assign res_free  = !out_valid_q || !out_stall;
	assign step      = valid_s1 && res_free;
	assign in_stall  = valid_s1 && !res_free;
	assign in_accept = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept)
			byte_s1 <= rx_byte;
	end

	// phase machine and data store
	lfd_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.rx_byte    (byte_s1),
		.sync_value (sync_q),
		.emit       (emit),
		.frame      (frame_d)
	);

	// result register, loads a finished frame or empties once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			frame_q <= frame_d;
	end

	assign out_valid  = out_valid_q;
	assign frame_id   = frame_q.id;
	assign data_count = frame_q.count;
	assign data_0     = frame_q.data[0];
	assign data_1     = frame_q.data[1];
	assign data_2     = frame_q.data[2];
	assign data_3     = frame_q.data[3];
	assign data_4     = frame_q.data[4];
	assign data_5     = frame_q.data[5];
	assign data_6     = frame_q.data[6];
	assign data_7     = frame_q.data[7];
	assign check_byte = frame_q.check;

endmodule

`default_nettype wire
